// ===== hw/rtl/ptd_pkg.sv =====
// Shared types and constants for the periodic task dispatcher.
// Holds action and status codes, controller state, and the command/status structs.
// No dependencies.
`default_nettype none

package ptd_pkg;

	localparam int unsigned SLOT_COUNT_DEF = 8;
	localparam logic [14:0] WDOG_LIMIT_RST = 15'd1000;

	// Action codes carried on the input transaction
	localparam logic [2:0] ACT_ADD    = 3'd0;
	localparam logic [2:0] ACT_REMOVE = 3'd1;
	localparam logic [2:0] ACT_TICK   = 3'd2;
	localparam logic [2:0] ACT_POLL   = 3'd3;
	localparam logic [2:0] ACT_DONE   = 3'd4;

	// Result status codes
	localparam logic [2:0] STS_OK         = 3'd0;
	localparam logic [2:0] STS_FAIL       = 3'd1;
	localparam logic [2:0] STS_DISPATCHED = 3'd2;
	localparam logic [2:0] STS_NOTHING    = 3'd3;
	localparam logic [2:0] STS_EXPIRED    = 3'd4;
	localparam logic [2:0] STS_BUSY       = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture the input transaction
		logic exec;      // act directly on the input ports, without a scan
		logic scan_init; // arm a slot scan
		logic from_pos;  // scan starts at the saved scan position
		logic scan;      // advance the slot scan
		logic commit;    // apply the scan outcome
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic running;
		logic pending;
		logic hit;
		logic scan_end;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptd_ctrl.sv =====
// Controller state machine for the periodic task dispatcher.
// Sequences direct actions and slot scans; depends on ptd_pkg.
`default_nettype none

module ptd_ctrl
	import ptd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [2:0] action,
	input  wire dp_sts_t    sts,
	output dp_cmd_t         cmd,
	output logic            busy
);

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (action == ACT_ADD || action == ACT_REMOVE ||
					    (action == ACT_POLL && !sts.running && sts.pending)) begin
						cmd.scan_init = 1'b1;
						cmd.from_pos  = (action == ACT_POLL);
						state_d       = ST_SCAN;
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.scan_end) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/ptd_dp.sv =====
// Datapath for the periodic task dispatcher: slot tables, tick counter,
// watchdog budget, slot scan pipeline and result register. Depends on ptd_pkg.
`default_nettype none

module ptd_dp
	import ptd_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_sts_t          sts,
	input  wire logic [2:0]  action,
	input  wire logic [7:0]  task_id,
	input  wire logic [15:0] period,
	input  wire logic        enable,
	input  wire logic        cfg_valid,
	input  wire logic [14:0] watchdog_limit,
	output logic             result_valid,
	output logic [2:0]       status,
	output logic [7:0]       dispatched_id
);

	localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOT_COUNT);

	// Slot tables: read at the scan pointer, registered read data
	logic [7:0]  task_mem [SLOT_COUNT];
	logic [15:0] per_mem  [SLOT_COUNT];
	logic        en_mem   [SLOT_COUNT];
	logic [31:0] last_mem [SLOT_COUNT];

	logic [SLOT_COUNT-1:0] valid_q;
	logic [SLOT_COUNT-1:0] ltv_q; // last tick written since reset or expiry

	logic [2:0]  op_q;
	logic [7:0]  id_q;
	logic [15:0] per_q;
	logic        en_q;

	logic [14:0]       limit_q;
	logic [31:0]       tick_q;
	logic              pending_q;
	logic [CNT_W-1:0]  pos_q;
	logic              running_q;
	logic [SLOT_W-1:0] run_slot_q;
	logic [15:0]       budget_q;

	logic [CNT_W-1:0]  ptr_q;
	logic              rd_valid_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              vld_s1;
	logic [7:0]        task_s1;
	logic [15:0]       per_s1;
	logic              en_s1;
	logic [31:0]       last_s1;
	logic              ltv_s1;

	logic              hit_q;
	logic [SLOT_W-1:0] hit_idx_q;
	logic [7:0]        hit_task_q;
	logic              free_found_q;
	logic [SLOT_W-1:0] free_idx_q;

	logic              result_valid_q;
	logic [2:0]        status_q;
	logic [7:0]        disp_q;

	logic              ptr_live;
	logic [SLOT_W-1:0] ptr_idx;
	logic [31:0]       elapsed;
	logic              match_s1;
	logic              due_s1;
	logic              hit_now;
	logic [15:0]       budget_dec;
	logic              expire;
	logic              add_new;
	logic              add_write;
	logic [SLOT_W-1:0] add_idx;
	logic              last_write;
	logic [2:0]        status_d;
	logic [7:0]        disp_d;

	assign ptr_live = (ptr_q < CNT_END);
	assign ptr_idx  = ptr_q[SLOT_W-1:0];

	// Elapsed ticks wrap mod 2^32; an unwritten last tick reads as zero
	assign elapsed  = tick_q - (ltv_s1 ? last_s1 : 32'd0);
	assign match_s1 = rd_valid_s1 && vld_s1 && (task_s1 == id_q);
	assign due_s1   = rd_valid_s1 && vld_s1 && en_s1 && (elapsed > {16'd0, per_s1});
	assign hit_now  = (op_q == ACT_POLL) ? due_s1 : match_s1;

	assign budget_dec = budget_q - 16'd1;
	assign expire     = running_q && (budget_dec == 16'd0);

	assign add_new    = cmd.commit && (op_q == ACT_ADD) && !hit_q && free_found_q;
	assign add_write  = cmd.commit && (op_q == ACT_ADD) && (hit_q || free_found_q);
	assign add_idx    = hit_q ? hit_idx_q : free_idx_q;
	assign last_write = cmd.exec && (action == ACT_DONE) && running_q;

	assign sts.running  = running_q;
	assign sts.pending  = pending_q;
	assign sts.hit      = hit_now;
	assign sts.scan_end = !rd_valid_s1 && !ptr_live;

	// Capture the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= ACT_ADD;
		end else if (cmd.load) begin
			op_q <= action;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q  <= task_id;
			per_q <= period;
			en_q  <= enable;
		end
	end

	// Slot tables and scan read stage
	always_ff @(posedge clk) begin
		if (add_new) begin
			task_mem[add_idx] <= id_q;
		end
		if (add_write) begin
			per_mem[add_idx] <= per_q;
			en_mem[add_idx]  <= en_q;
		end
		if (last_write) begin
			last_mem[run_slot_q] <= tick_q;
		end
		if (ptr_live) begin
			task_s1 <= task_mem[ptr_idx];
			per_s1  <= per_mem[ptr_idx];
			en_s1   <= en_mem[ptr_idx];
			last_s1 <= last_mem[ptr_idx];
			ltv_s1  <= ltv_q[ptr_idx];
			vld_s1  <= valid_q[ptr_idx];
			idx_s1  <= ptr_idx;
		end
	end

	// Scan pointer and outcome tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			rd_valid_s1  <= 1'b0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			hit_task_q   <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			rd_valid_s1 <= cmd.scan && ptr_live;
			if (cmd.scan_init) begin
				ptr_q        <= cmd.from_pos ? pos_q : '0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else if (cmd.scan) begin
				if (ptr_live) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
				if (hit_now) begin
					hit_q      <= 1'b1;
					hit_idx_q  <= idx_s1;
					hit_task_q <= task_s1;
				end
				// Remember the first free slot for an add of a new id
				if (rd_valid_s1 && !vld_s1 && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
			end
		end
	end

	// Scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= WDOG_LIMIT_RST;
			valid_q    <= '0;
			ltv_q      <= '0;
			tick_q     <= '0;
			pending_q  <= 1'b0;
			pos_q      <= '0;
			running_q  <= 1'b0;
			run_slot_q <= '0;
			budget_q   <= '0;
		end else begin
			if (cfg_valid) begin
				limit_q <= watchdog_limit;
			end
			if (cmd.exec) begin
				unique case (action)
					ACT_TICK: begin
						if (expire) begin
							// Watchdog fired: drop all scheduler state
							valid_q    <= '0;
							ltv_q      <= '0;
							tick_q     <= '0;
							pending_q  <= 1'b0;
							pos_q      <= '0;
							running_q  <= 1'b0;
							run_slot_q <= '0;
							budget_q   <= '0;
						end else begin
							tick_q    <= tick_q + 32'd1;
							pending_q <= 1'b1;
							if (running_q) begin
								budget_q <= budget_dec;
							end
						end
					end
					ACT_DONE: begin
						if (running_q) begin
							ltv_q[run_slot_q] <= 1'b1;
							pos_q             <= CNT_W'(run_slot_q) + CNT_W'(1);
							running_q         <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				unique case (op_q)
					ACT_ADD: begin
						if (!hit_q && free_found_q) begin
							valid_q[free_idx_q] <= 1'b1;
						end
					end
					ACT_REMOVE: begin
						if (hit_q) begin
							valid_q[hit_idx_q] <= 1'b0;
						end
					end
					ACT_POLL: begin
						if (hit_q) begin
							running_q  <= 1'b1;
							run_slot_q <= hit_idx_q;
							pos_q      <= CNT_W'(hit_idx_q);
							budget_q   <= {1'b0, limit_q};
						end else begin
							// Scan finished: drop pending ticks and rewind
							pending_q <= 1'b0;
							pos_q     <= '0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result selection
	always_comb begin
		status_d = STS_FAIL;
		disp_d   = 8'd0;
		if (cmd.commit) begin
			unique case (op_q)
				ACT_ADD:    status_d = (hit_q || free_found_q) ? STS_OK : STS_FAIL;
				ACT_REMOVE: status_d = hit_q ? STS_OK : STS_FAIL;
				ACT_POLL: begin
					status_d = hit_q ? STS_DISPATCHED : STS_NOTHING;
					disp_d   = hit_q ? hit_task_q : 8'd0;
				end
				default:    status_d = STS_FAIL;
			endcase
		end else begin
			unique case (action)
				ACT_TICK: status_d = expire ? STS_EXPIRED : STS_OK;
				ACT_POLL: status_d = running_q ? STS_BUSY : STS_NOTHING;
				ACT_DONE: status_d = running_q ? STS_OK : STS_FAIL;
				default:  status_d = STS_FAIL;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.exec || cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.commit) begin
			status_q <= status_d;
			disp_q   <= disp_d;
		end
	end

	assign result_valid  = result_valid_q;
	assign status        = status_q;
	assign dispatched_id = disp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_task_dispatcher_core.sv =====
// Periodic task dispatcher, top level. Tick, done, unknown actions and polls that
// cannot scan never raise busy; the result is registered next cycle, one per cycle.
// Add and remove walk the slot table one slot per cycle through a single read port:
// busy stays high until the walk ends, early when a matching slot is found.
// A scanning poll walks from the saved scan position; a dispatch ends it early.
// Results strobe in the same cycle that busy drops; the receiver cannot stall.
// arst_n clears the table, counters and watchdog; watchdog_limit resets to 1000.
`default_nettype none

module periodic_task_dispatcher_core
	import ptd_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  action,
	input  wire logic [7:0]  task_id,
	input  wire logic [15:0] period,
	input  wire logic        enable,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [14:0] watchdog_limit,
	output logic             result_valid,
	output logic [2:0]       status,
	output logic [7:0]       dispatched_id
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	ptd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ptd_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (action),
		.task_id        (task_id),
		.period         (period),
		.enable         (enable),
		.cfg_valid      (cfg_valid),
		.watchdog_limit (watchdog_limit),
		.result_valid   (result_valid),
		.status         (status),
		.dispatched_id  (dispatched_id)
	);

endmodule

`default_nettype wire

// ===== dv/tb_periodic_task_dispatcher_core.sv =====
// Testbench for periodic_task_dispatcher_core: a directed table, then random traffic
// checked against an in-bench dispatcher predictor. Depends on ptd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_periodic_task_dispatcher_core
	import ptd_pkg::*;
();

	localparam int SLOTS = SLOT_COUNT_DEF;
	localparam int SETTLE_CYCLES = SLOTS + 4;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 110;

	typedef struct packed {
		logic [2:0]  act;
		logic [7:0]  id;
		logic [15:0] per;
		logic        en;
	} cmd_t;

	typedef struct packed {
		logic [2:0] st;
		logic [7:0] id;
	} disp_result_t;

	typedef struct packed {
		cmd_t       cmd;
		logic       typed;
		logic [2:0] want_st;
	} table_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  action = ACT_ADD;
	logic [7:0]  task_id = 8'd0;
	logic [15:0] period = 16'd0;
	logic        enable = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [14:0] watchdog_limit = WDOG_LIMIT_RST;
	logic        result_valid;
	logic [2:0]  status;
	logic [7:0]  dispatched_id;

	// Predictor state
	logic        ent_used [SLOTS];
	logic [7:0]  ent_task [SLOTS];
	logic [15:0] ent_period [SLOTS];
	logic        ent_en [SLOTS];
	logic [31:0] ent_last [SLOTS];
	logic [31:0] tick_now;
	logic        scan_armed;
	int          scan_start;
	logic        run_active;
	int          run_entry;
	logic [15:0] run_left;
	logic [14:0] limit_shadow = WDOG_LIMIT_RST;

	disp_result_t expected_results [$];
	table_row_t   directed_rows [$];
	int           fail_count = 0;
	int           idle_cycles = 0;

	periodic_task_dispatcher_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.task_id       (task_id),
		.period        (period),
		.enable        (enable),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.watchdog_limit(watchdog_limit),
		.result_valid  (result_valid),
		.status        (status),
		.dispatched_id (dispatched_id)
	);

	always begin
		#2 clk = 1'b0;
		#2 clk = 1'b1;
	end

	function automatic void clear_dispatch_state();
		for (int i = 0; i < SLOTS; i++) begin
			ent_used[i] = 1'b0;
			ent_task[i] = 8'd0;
			ent_period[i] = 16'd0;
			ent_en[i] = 1'b0;
			ent_last[i] = 32'd0;
		end
		tick_now = 32'd0;
		scan_armed = 1'b0;
		scan_start = 0;
		run_active = 1'b0;
		run_entry = 0;
		run_left = 16'd0;
	endfunction

	function automatic disp_result_t dispatch_predict(cmd_t c);
		disp_result_t r;
		int hit;
		logic [31:0] elapsed;
		r.st = STS_FAIL;
		r.id = 8'd0;
		hit = -1;
		case (c.act)
			ACT_ADD: begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && ent_used[i] && ent_task[i] == c.id) hit = i;
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && !ent_used[i]) hit = i;
				// a fresh slot keeps whatever last-run tick it held
				if (hit >= 0) begin
					ent_used[hit] = 1'b1;
					ent_task[hit] = c.id;
					ent_period[hit] = c.per;
					ent_en[hit] = c.en;
					r.st = STS_OK;
				end
			end
			ACT_REMOVE: begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && ent_used[i] && ent_task[i] == c.id) hit = i;
				if (hit >= 0) begin
					ent_used[hit] = 1'b0;
					r.st = STS_OK;
				end
			end
			ACT_TICK: begin
				tick_now = tick_now + 32'd1;
				scan_armed = 1'b1;
				r.st = STS_OK;
				if (run_active) begin
					run_left = run_left - 16'd1;
					if (run_left == 16'd0) begin
						clear_dispatch_state();
						r.st = STS_EXPIRED;
					end
				end
			end
			ACT_POLL: begin
				if (run_active) begin
					r.st = STS_BUSY;
				end else if (!scan_armed) begin
					r.st = STS_NOTHING;
				end else begin
					for (int i = scan_start; i < SLOTS; i++) begin
						elapsed = tick_now - ent_last[i];
						if (hit < 0 && ent_used[i] && ent_en[i] && elapsed > {16'd0, ent_period[i]})
							hit = i;
					end
					if (hit >= 0) begin
						run_active = 1'b1;
						run_entry = hit;
						scan_start = hit;
						run_left = {1'b0, limit_shadow};
						r.st = STS_DISPATCHED;
						r.id = ent_task[hit];
					end else begin
						// scan over: drop pending ticks and rewind
						scan_armed = 1'b0;
						scan_start = 0;
						r.st = STS_NOTHING;
					end
				end
			end
			ACT_DONE: begin
				if (run_active) begin
					ent_last[run_entry] = tick_now;
					scan_start = run_entry + 1;
					run_active = 1'b0;
					r.st = STS_OK;
				end
			end
			default: r.st = STS_FAIL;
		endcase
		return r;
	endfunction

	// Hold the command until the block takes it; start stays high for the caller.
	task automatic issue_command(cmd_t c, logic typed, logic [2:0] typed_st);
		disp_result_t guess;
		start <= 1'b1;
		action <= c.act;
		task_id <= c.id;
		period <= c.per;
		enable <= c.en;
		do @(posedge clk); while (busy);
		guess = dispatch_predict(c);
		if (typed) begin
			guess.st = typed_st;
			guess.id = 8'd0;
		end
		expected_results.push_back(guess);
	endtask

	task automatic pause_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (expected_results.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_limit(logic [14:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		watchdog_limit <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_shadow = value;
	endtask

	task automatic add_row(logic [2:0] a, logic [7:0] id, logic [15:0] per, logic en,
			logic typed, logic [2:0] st);
		table_row_t row;
		row.cmd = '{a, id, per, en};
		row.typed = typed;
		row.want_st = st;
		directed_rows.push_back(row);
	endtask

	function automatic logic [7:0] pick_task_id();
		// mostly a small pool so adds collide, removes hit and the table fills
		if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 11));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		int pick;
		pick = $urandom_range(0, 99);
		c.id = pick_task_id();
		c.per = 16'($urandom);
		c.en = 1'($urandom);
		if (pick < 22) begin
			c.act = ACT_ADD;
			pick = $urandom_range(0, 9);
			if (pick < 7) c.per = 16'($urandom_range(0, 4));
			else if (pick < 9) c.per = 16'($urandom_range(0, 300));
			c.en = ($urandom_range(0, 9) < 8);
		end else if (pick < 32) begin
			c.act = ACT_REMOVE;
		end else if (pick < 58) begin
			c.act = ACT_TICK;
		end else if (pick < 82) begin
			c.act = ACT_POLL;
		end else if (pick < 96) begin
			c.act = ACT_DONE;
		end else begin
			c.act = 3'($urandom_range(5, 7));
		end
		return c;
	endfunction

	always @(posedge clk) begin
		disp_result_t want;
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result: status %0d id %0d", status, dispatched_id);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.st || dispatched_id !== want.id) begin
					if (fail_count < 10)
						$display("mismatch: status exp %0d got %0d, id exp %0d got %0d",
							want.st, status, want.id, dispatched_id);
					fail_count++;
				end
			end
		end
	end

	// Stop the run if no transaction of any kind moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [14:0] phase_limits [8];
		int burst_left;
		clear_dispatch_state();
		phase_limits = '{15'd1, 15'd3, 15'd0, 15'd32767, 15'd2, 15'd1000, 15'd5, 15'd1};
		phase_limits[7] = 15'($urandom_range(1, 40));
		burst_left = 0;

		add_row(ACT_POLL,   8'd0,   16'd0,     1'b0, 1'b1, STS_NOTHING);
		add_row(ACT_DONE,   8'd0,   16'd0,     1'b0, 1'b1, STS_FAIL);
		add_row(ACT_REMOVE, 8'd255, 16'd0,     1'b0, 1'b1, STS_FAIL);
		add_row(3'd5,       8'd255, 16'd65535, 1'b1, 1'b1, STS_FAIL);
		add_row(3'd6,       8'd0,   16'd0,     1'b0, 1'b1, STS_FAIL);
		add_row(3'd7,       8'd170, 16'd21845, 1'b1, 1'b1, STS_FAIL);
		add_row(ACT_TICK,   8'd0,   16'd0,     1'b0, 1'b1, STS_OK);
		add_row(ACT_ADD,    8'd0,   16'd0,     1'b1, 1'b1, STS_OK);
		add_row(ACT_ADD,    8'd255, 16'd65535, 1'b0, 1'b1, STS_OK);
		add_row(ACT_ADD,    8'd0,   16'd1,     1'b1, 1'b1, STS_OK);
		for (int i = 10; i < 16; i++)
			add_row(ACT_ADD, 8'(i), 16'd0, 1'b1, 1'b1, STS_OK);
		add_row(ACT_ADD,    8'd99,  16'd0,     1'b1, 1'b1, STS_FAIL);
		add_row(ACT_REMOVE, 8'd255, 16'd0,     1'b0, 1'b1, STS_OK);
		add_row(ACT_TICK,   8'd0,   16'd0,     1'b0, 1'b1, STS_OK);
		add_row(ACT_POLL,   8'd0,   16'd0,     1'b0, 1'b0, STS_OK);
		add_row(ACT_POLL,   8'd0,   16'd0,     1'b0, 1'b1, STS_BUSY);
		add_row(ACT_TICK,   8'd0,   16'd0,     1'b0, 1'b0, STS_OK);
		add_row(ACT_DONE,   8'd0,   16'd0,     1'b0, 1'b1, STS_OK);
		add_row(ACT_POLL,   8'd0,   16'd0,     1'b0, 1'b0, STS_OK);
		add_row(ACT_DONE,   8'd0,   16'd0,     1'b0, 1'b0, STS_OK);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want_st);

		foreach (phase_limits[p]) begin
			program_limit(phase_limits[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				issue_command(random_command(), 1'b0, STS_OK);
				if ($urandom_range(0, 59) == 0) begin
					drain_results();
				end else if (burst_left == 0) begin
					pause_sender($urandom_range(1, 12));
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
						: $urandom_range(1, 16);
				end else begin
					burst_left--;
				end
			end
		end

		drain_results();
		fail_count += expected_results.size();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== periodic_task_dispatcher_core.f =====
hw/rtl/ptd_pkg.sv
hw/rtl/ptd_ctrl.sv
hw/rtl/ptd_dp.sv
hw/rtl/periodic_task_dispatcher_core.sv
dv/tb_periodic_task_dispatcher_core.sv
